@@ src/msc_pkg.sv @@
`timescale 1ns / 1ps
// msc_pkg: opcode and function codes, the execute result struct and the
// channel codes shared by the core modules. No dependencies.
package msc_pkg;

  // item codes on the input stream
  localparam logic [1:0] OP_EXEC = 2'd0;
  localparam logic [1:0] OP_IWR  = 2'd1;
  localparam logic [1:0] OP_DWR  = 2'd2;

  // configuration register indexes
  localparam logic CFG_START_PC = 1'b0;
  localparam logic CFG_INIT_SP  = 1'b1;

  // primary opcodes
  localparam logic [5:0] OPC_RTYPE = 6'h00;
  localparam logic [5:0] OPC_J     = 6'h02;
  localparam logic [5:0] OPC_JAL   = 6'h03;
  localparam logic [5:0] OPC_BEQ   = 6'h04;
  localparam logic [5:0] OPC_BNE   = 6'h05;
  localparam logic [5:0] OPC_ADDI  = 6'h08;
  localparam logic [5:0] OPC_SLTI  = 6'h0A;
  localparam logic [5:0] OPC_ANDI  = 6'h0C;
  localparam logic [5:0] OPC_ORI   = 6'h0D;
  localparam logic [5:0] OPC_NORI  = 6'h0E;
  localparam logic [5:0] OPC_LUI   = 6'h0F;
  localparam logic [5:0] OPC_LB    = 6'h20;
  localparam logic [5:0] OPC_LH    = 6'h21;
  localparam logic [5:0] OPC_LW    = 6'h23;
  localparam logic [5:0] OPC_LBU   = 6'h24;
  localparam logic [5:0] OPC_LHU   = 6'h25;
  localparam logic [5:0] OPC_SB    = 6'h28;
  localparam logic [5:0] OPC_SH    = 6'h29;
  localparam logic [5:0] OPC_SW    = 6'h2B;
  localparam logic [5:0] OPC_HALT  = 6'h3F;

  // function codes of register-type words
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_NAND = 6'h28;
  localparam logic [5:0] FN_SLT  = 6'h2A;

  localparam logic [4:0] REG_SP = 5'd29;
  localparam logic [4:0] REG_RA = 5'd31;

  // outcome of the execute unit for one instruction word
  typedef struct packed {
    logic        wr_en;
    logic [4:0]  wr_idx;
    logic [31:0] wr_val;
    logic        ez;
    logic        ov;
    logic        ad;
    logic        mis;
    logic        halt;
    logic        mem;
    logic [31:0] nxt;
    logic [31:0] addr;
  } exe_t;

endpackage

@@ src/msc_ram.sv @@
`timescale 1ns / 1ps
// msc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module msc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/msc_alu.sv @@
`timescale 1ns / 1ps
// msc_alu: execute unit; decodes one instruction word with its register
// operands and program counter. Depends on msc_pkg.
module msc_alu #(
  parameter int DATA_BYTES = 1024
) (
  input  logic [31:0]   ir,
  input  logic [31:0]   a,
  input  logic [31:0]   b,
  input  logic [31:0]   pc,
  output msc_pkg::exe_t res
);

  localparam logic [32:0] LAST_BYTE = 33'(DATA_BYTES - 1);

  logic [5:0]  opc;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] imm;
  logic [31:0] zimm;
  logic [31:0] pc4;
  logic [31:0] jtgt;
  logic [31:0] boff;
  logic [31:0] sum;
  logic [32:0] last;
  logic [2:0]  size;
  logic        put;
  logic [4:0]  dest;
  logic [31:0] val;

  assign opc  = ir[31:26];
  assign rt   = ir[20:16];
  assign rd   = ir[15:11];
  assign sh   = ir[10:6];
  assign fn   = ir[5:0];
  assign imm  = {{16{ir[15]}}, ir[15:0]};
  assign zimm = {16'd0, ir[15:0]};
  assign pc4  = pc + 32'd4;
  assign jtgt = {pc4[31:28], ir[25:0], 2'b00};
  assign boff = 32'd4 + {imm[29:0], 2'b00};

  always_comb begin
    res  = '0;
    put  = 1'b0;
    dest = rd;
    val  = '0;
    sum  = a + imm;
    last = '0;
    size = 3'd1;
    res.nxt  = pc4;
    res.addr = sum;
    if (opc == msc_pkg::OPC_RTYPE) begin
      case (fn)
        msc_pkg::FN_ADD: begin
          val = a + b; put = 1'b1;
          res.ov = ~(a[31] ^ b[31]) & (a[31] ^ val[31]);
        end
        msc_pkg::FN_SUB: begin
          val = a - b; put = 1'b1;
          res.ov = (a[31] ^ b[31]) & (a[31] ^ val[31]);
        end
        msc_pkg::FN_AND:  begin val = a & b;    put = 1'b1; end
        msc_pkg::FN_OR:   begin val = a | b;    put = 1'b1; end
        msc_pkg::FN_XOR:  begin val = a ^ b;    put = 1'b1; end
        msc_pkg::FN_NOR:  begin val = ~(a | b); put = 1'b1; end
        msc_pkg::FN_NAND: begin val = ~(a & b); put = 1'b1; end
        msc_pkg::FN_SLT: begin
          val = {31'd0, $signed(a) < $signed(b)}; put = 1'b1;
        end
        msc_pkg::FN_SLL: begin
          // all-zero word is a nop
          val = b << sh;
          put = !(rd == 5'd0 && rt == 5'd0 && sh == 5'd0);
        end
        msc_pkg::FN_SRL: begin val = b >> sh; put = 1'b1; end
        msc_pkg::FN_SRA: begin val = $signed(b) >>> sh; put = 1'b1; end
        msc_pkg::FN_JR:  res.nxt = a;
        default: ;
      endcase
    end else begin
      dest = rt;
      case (opc)
        msc_pkg::OPC_J: res.nxt = jtgt;
        msc_pkg::OPC_JAL: begin
          res.nxt = jtgt; dest = msc_pkg::REG_RA; val = pc4; put = 1'b1;
        end
        msc_pkg::OPC_HALT: begin
          res.halt = 1'b1; res.nxt = pc;
        end
        msc_pkg::OPC_ADDI: begin
          val = sum; put = 1'b1;
          res.ov = ~(a[31] ^ imm[31]) & (a[31] ^ sum[31]);
        end
        msc_pkg::OPC_LUI:  begin val = {ir[15:0], 16'd0}; put = 1'b1; end
        msc_pkg::OPC_ANDI: begin val = a & zimm;    put = 1'b1; end
        msc_pkg::OPC_ORI:  begin val = a | zimm;    put = 1'b1; end
        msc_pkg::OPC_NORI: begin val = ~(a | zimm); put = 1'b1; end
        msc_pkg::OPC_SLTI: begin
          val = {31'd0, $signed(a) < $signed(imm)}; put = 1'b1;
        end
        msc_pkg::OPC_BEQ, msc_pkg::OPC_BNE: begin
          val = pc + boff;
          res.ov = ~(pc[31] ^ boff[31]) & (pc[31] ^ val[31]);
          if ((opc == msc_pkg::OPC_BEQ) == (a == b)) begin
            res.nxt = val;
          end
          val = '0;
        end
        msc_pkg::OPC_LW, msc_pkg::OPC_LH, msc_pkg::OPC_LHU, msc_pkg::OPC_LB,
        msc_pkg::OPC_LBU, msc_pkg::OPC_SW, msc_pkg::OPC_SH, msc_pkg::OPC_SB: begin
          // effective address checks
          res.ov = ~(a[31] ^ imm[31]) & (a[31] ^ sum[31]);
          if (opc == msc_pkg::OPC_LW || opc == msc_pkg::OPC_SW) begin
            size = 3'd4;
          end else if (opc == msc_pkg::OPC_LH || opc == msc_pkg::OPC_LHU ||
                       opc == msc_pkg::OPC_SH) begin
            size = 3'd2;
          end
          if (opc < msc_pkg::OPC_SB && rt == 5'd0) begin
            res.ez = 1'b1;
          end
          last   = {1'b0, sum} + 33'(size) - 33'd1;
          res.ad = sum[31] | (last > LAST_BYTE);
          res.mis = (size == 3'd4) ? (sum[1:0] != 2'b00)
                  : (size == 3'd2) ? sum[0] : 1'b0;
          if (res.ad || res.mis) begin
            res.halt = 1'b1; res.nxt = pc;
          end else begin
            res.mem = 1'b1;
          end
        end
        default: ;
      endcase
    end
    // register write, suppressed for register zero
    if (put) begin
      if (dest == 5'd0) begin
        res.ez = 1'b1;
      end else begin
        res.wr_en  = 1'b1;
        res.wr_idx = dest;
        res.wr_val = val;
      end
    end
  end

endmodule

@@ src/mips_subset_single_cycle_core_top.sv @@
`timescale 1ns / 1ps
// mips_subset_single_cycle_core_top: sequencer of the core around its
// instruction, data and register memories. Depends on msc_pkg, msc_ram, msc_alu.

// After reset the core sweeps all memories to zero, one entry a cycle, over
// max(INSTR_WORDS, DATA_BYTES/4, 32) entries (256 at the defaults) and takes no
// item meanwhile; configuration writes are taken at any time. Word writes and
// idle items go from the idle state straight to the result. An execute item
// passes fetch, register read, execute and result, and loads and stores add a
// data memory step, set by the registered read of the instruction, register and
// data memories that one instruction visits in turn; steps that fetch nothing
// go straight to the result. One item is in work at a time, and a new one is
// accepted while the previous result still waits on the output.
module mips_subset_single_cycle_core_top #(
  parameter int DATA_BYTES  = 1024,
  parameter int INSTR_WORDS = 256
) (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // op[1:0], word_index[9:2], load_word[41:10]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata   // next_pc[31:0], halted, executed,
                                     // err_write_zero, err_overflow, err_address,
                                     // err_misaligned, reg_written, reg_index[43:39],
                                     // reg_value[75:44]
);

  localparam int DATA_WORDS = DATA_BYTES / 4;
  localparam int IAW = $clog2(INSTR_WORDS);
  localparam int DAW = $clog2(DATA_WORDS);
  localparam int CLR_A = (INSTR_WORDS > DATA_WORDS) ? INSTR_WORDS : DATA_WORDS;
  localparam int CLR_N = (CLR_A > 32) ? CLR_A : 32;
  localparam int CAW = $clog2(CLR_N);
  localparam logic [31:0] PC_LIMIT = 32'(INSTR_WORDS * 4);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_EXE   = 3'd3;
  localparam logic [2:0] S_MEM   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]     state;
  logic [CAW-1:0] clr;
  logic [31:0]    start_pc;
  logic [31:0]    initial_sp;
  logic [31:0]    program_counter;
  logic           halted_flag;
  logic           started_flag;
  logic [31:0]    ir;
  logic [31:0]    ad_r;
  logic [31:0]    b_r;
  // result flags of the item in work
  logic           exe_f, ez_f, ov_f, ad_f, mis_f, rw_f;
  logic [4:0]     ri_f;
  logic [31:0]    rv_f;

  logic [1:0]  in_op;
  logic [7:0]  in_idx;
  logic [31:0] in_word;
  logic        take;
  logic [31:0] pc_cur;
  logic [31:0] pc_off;

  logic           imem_we;
  logic [IAW-1:0] imem_waddr;
  logic [31:0]    imem_wdata;
  logic [31:0]    imem_rdata;
  logic           dmem_we;
  logic [DAW-1:0] dmem_waddr;
  logic [31:0]    dmem_wdata;
  logic [31:0]    dmem_rdata;
  logic           rf_we;
  logic [4:0]     rf_waddr;
  logic [31:0]    rf_wdata;
  logic [31:0]    rfa_rdata;
  logic [31:0]    rfb_rdata;

  msc_pkg::exe_t exu;
  logic [5:0]    mopc;
  logic [4:0]    mrt;
  logic [31:0]   ld_val;
  logic [31:0]   st_word;
  logic          is_load;

  assign in_op   = s_axis_tdata[1:0];
  assign in_idx  = s_axis_tdata[9:2];
  assign in_word = s_axis_tdata[41:10];
  assign s_axis_tready = (state == S_IDLE);
  assign take    = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign pc_cur  = started_flag ? program_counter : start_pc;
  assign pc_off  = pc_cur - start_pc;

  // memories
  msc_ram #(.WIDTH(32), .DEPTH(INSTR_WORDS)) u_imem (
    .clk(clk), .we(imem_we), .waddr(imem_waddr), .wdata(imem_wdata),
    .raddr(pc_off[IAW+1:2]), .rdata(imem_rdata)
  );
  msc_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
    .clk(clk), .we(dmem_we), .waddr(dmem_waddr), .wdata(dmem_wdata),
    .raddr(exu.addr[DAW+1:2]), .rdata(dmem_rdata)
  );
  msc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(imem_rdata[25:21]), .rdata(rfa_rdata)
  );
  msc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(imem_rdata[20:16]), .rdata(rfb_rdata)
  );

  msc_alu #(.DATA_BYTES(DATA_BYTES)) u_alu (
    .ir(ir), .a(rfa_rdata), .b(rfb_rdata), .pc(program_counter), .res(exu)
  );

  // load extraction and store merge on the fetched data word
  assign mopc    = ir[31:26];
  assign mrt     = ir[20:16];
  assign is_load = (mopc < msc_pkg::OPC_SB);
  always_comb begin
    logic [7:0]  bsel;
    logic [15:0] hsel;
    bsel = dmem_rdata[8*(3-ad_r[1:0]) +: 8];
    hsel = ad_r[1] ? dmem_rdata[15:0] : dmem_rdata[31:16];
    case (mopc)
      msc_pkg::OPC_LW:  ld_val = dmem_rdata;
      msc_pkg::OPC_LH:  ld_val = {{16{hsel[15]}}, hsel};
      msc_pkg::OPC_LHU: ld_val = {16'd0, hsel};
      msc_pkg::OPC_LB:  ld_val = {{24{bsel[7]}}, bsel};
      default:          ld_val = {24'd0, bsel};
    endcase
    st_word = dmem_rdata;
    case (mopc)
      msc_pkg::OPC_SW: st_word = b_r;
      msc_pkg::OPC_SH: begin
        if (ad_r[1]) st_word[15:0] = b_r[15:0];
        else st_word[31:16] = b_r[15:0];
      end
      default: st_word[8*(3-ad_r[1:0]) +: 8] = b_r[7:0];
    endcase
  end

  // memory write ports
  always_comb begin
    imem_we    = 1'b0;
    imem_waddr = IAW'(clr);
    imem_wdata = '0;
    dmem_we    = 1'b0;
    dmem_waddr = DAW'(clr);
    dmem_wdata = '0;
    rf_we      = 1'b0;
    rf_waddr   = clr[4:0];
    rf_wdata   = '0;
    case (state)
      S_CLEAR: begin
        imem_we = 1'b1; dmem_we = 1'b1; rf_we = 1'b1;
      end
      S_IDLE: begin
        if (take && in_op == msc_pkg::OP_IWR && 32'(in_idx) < 32'(INSTR_WORDS)) begin
          imem_we = 1'b1; imem_waddr = IAW'(in_idx); imem_wdata = in_word;
        end
        if (take && in_op == msc_pkg::OP_DWR && 32'(in_idx) < 32'(DATA_WORDS)) begin
          dmem_we = 1'b1; dmem_waddr = DAW'(in_idx); dmem_wdata = in_word;
        end
        if (take && in_op == msc_pkg::OP_EXEC && !started_flag) begin
          rf_we = 1'b1; rf_waddr = msc_pkg::REG_SP; rf_wdata = initial_sp;
        end
      end
      S_EXE: begin
        rf_we = exu.wr_en; rf_waddr = exu.wr_idx; rf_wdata = exu.wr_val;
      end
      S_MEM: begin
        if (is_load) begin
          rf_we = (mrt != 5'd0); rf_waddr = mrt; rf_wdata = ld_val;
        end else begin
          dmem_we = 1'b1; dmem_waddr = ad_r[DAW+1:2]; dmem_wdata = st_word;
        end
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc   <= '0;
      initial_sp <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        msc_pkg::CFG_START_PC: start_pc <= cfg_data;
        msc_pkg::CFG_INIT_SP:  initial_sp <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr             <= '0;
      program_counter <= '0;
      halted_flag     <= 1'b0;
      started_flag    <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      // a result leaves unless the next one replaces it in this cycle
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + CAW'(1);
          if (clr == CAW'(CLR_N - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            {exe_f, ez_f, ov_f, ad_f, mis_f, rw_f} <= '0;
            ri_f  <= '0;
            rv_f  <= '0;
            state <= S_OUT;
            if (in_op == msc_pkg::OP_EXEC) begin
              started_flag    <= 1'b1;
              program_counter <= pc_cur;
              if (!halted_flag) begin
                if (pc_cur >= PC_LIMIT) begin
                  halted_flag <= 1'b1;
                end else if (pc_cur < start_pc) begin
                  program_counter <= pc_cur + 32'd4;
                end else if (pc_off[1:0] != 2'b00) begin
                  halted_flag <= 1'b1;
                end else begin
                  exe_f <= 1'b1;
                  state <= S_DEC;
                end
              end
            end
          end
        end
        S_DEC: begin
          ir    <= imem_rdata;
          state <= S_EXE;
        end
        S_EXE: begin
          ez_f  <= exu.ez;
          ov_f  <= exu.ov;
          ad_f  <= exu.ad;
          mis_f <= exu.mis;
          rw_f  <= exu.wr_en;
          if (exu.wr_en) begin
            ri_f <= exu.wr_idx;
            rv_f <= exu.wr_val;
          end
          if (exu.halt) begin
            halted_flag <= 1'b1;
          end
          ad_r <= exu.addr;
          b_r  <= rfb_rdata;
          if (exu.mem) begin
            state <= S_MEM;
          end else begin
            program_counter <= exu.nxt;
            state <= S_OUT;
          end
        end
        S_MEM: begin
          if (is_load) begin
            if (mrt == 5'd0) begin
              ez_f <= 1'b1;
            end else begin
              rw_f <= 1'b1;
              ri_f <= mrt;
              rv_f <= ld_val;
            end
          end
          program_counter <= program_counter + 32'd4;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {4'd0, rv_f, ri_f, rw_f, mis_f, ad_f, ov_f, ez_f, exe_f,
                       halted_flag, program_counter};
    end
  end

endmodule

@@ src/msc_chk.sv @@
`timescale 1ns / 1ps
// msc_chk: port-level checks on the core's result stream, bound to the top
// level. Depends on mips_subset_single_cycle_core_top.
module msc_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // register zero is never reported written
  a_no_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[38] |-> m_axis_tdata[43:39] != 5'd0)
    else $error("write to register zero reported");

  // address faults stop the machine
  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[36] || m_axis_tdata[37]) |-> m_axis_tdata[32])
    else $error("address fault without halt");

  // no write means index and value are zero
  a_no_write: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[38] |-> m_axis_tdata[75:39] == 37'd0)
    else $error("stale register write fields");

endmodule

bind mips_subset_single_cycle_core_top msc_chk u_msc_chk (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
